// ===== rtl/core/mcba_pkg.sv =====
// ----------------------------------------------------------------------------
// mcba_pkg
// shared types, codes and helpers of the chunk pool allocator
// ----------------------------------------------------------------------------
package mcba_pkg;

    localparam int MAX_CHUNKS_DEF = 64;

    localparam int CB_W      = 25;
    localparam int CCNT_W    = 7;
    localparam int SIZE_W    = 32;
    localparam int CIDX_W    = 6;
    localparam int STAT_W    = 3;
    localparam int OFF_W     = 30;
    localparam int FREE_W    = 7;
    localparam int TALLY_W   = 32;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_STEPS = 2;
    localparam int QDEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOST_REG    = 2'd2;

    localparam logic [CB_W-1:0]   CB_RESET   = 25'd4096;
    localparam logic [CCNT_W-1:0] CCNT_RESET = 7'd64;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_UNREG    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OUT      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_DOUBLE   = 3'd5;

    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_ALLOC  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] size_bytes;
        logic [CIDX_W-1:0] chunk_index;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [CIDX_W-1:0]  granted_chunk;
        logic [OFF_W-1:0]   byte_offset;
        logic               last;
        logic [SIZE_W-1:0]  shortfall;
        logic [FREE_W-1:0]  free_chunks;
        logic [TALLY_W-1:0] exhausted_count;
    } rsp_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [STAT_W-1:0] status;
        logic [SIZE_W-1:0] need;
        logic [CIDX_W-1:0] chunk_index;
    } job_t;

    typedef struct packed {
        logic [CB_W-1:0]   chunk_bytes;
        logic [CCNT_W-1:0] chunk_count;
        logic              host_ready;
    } cfg_t;

    function automatic logic [CB_W-1:0] eff_bytes(input logic [CB_W-1:0] cb);
        return (cb == '0) ? CB_W'(1) : cb;
    endfunction

endpackage

// ===== rtl/core/multi_chunk_buffer_allocator.sv =====
// ----------------------------------------------------------------------------
// multi_chunk_buffer_allocator
// fixed size chunk pool with a free bitmap, multi-chunk allocate and free
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Free, zero-size and
// unregistered requests go straight into the job queue, and their one beat is
// registered onto rsp when the back pops the job. An allocate holds busy
// while a radix-4 divider gets the chunk count; the job is then queued, and
// the back answers with a shortfall beat or enters its grant state and sends
// granted beats one per cycle, lowest index first, while no chunk count write
// refills the pool. A short job queue lets the front take the next request
// while the back is still granting; busy is also high while that queue is
// full. Each beat sits on rsp for one cycle with rsp_strobe high; the
// receiver cannot stall. A write to the chunk count register refills the
// pool in the cycle after the write.
module multi_chunk_buffer_allocator #(
    parameter int MAX_CHUNKS = mcba_pkg::MAX_CHUNKS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mcba_pkg::req_t                   req,
    output mcba_pkg::rsp_t                   rsp,
    output logic                             rsp_strobe,
    input  logic                             cfg_we,
    input  logic [mcba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcba_pkg::CFG_W-1:0]       cfg_data
);
    import mcba_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic refill_reg;
    logic push, pop, empty, full;
    job_t job_in, job_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CHUNK_BYTES: cfg_next.chunk_bytes = cfg_data[CB_W-1:0];
                REG_CHUNK_COUNT: cfg_next.chunk_count = cfg_data[CCNT_W-1:0];
                REG_HOST_REG:    cfg_next.host_ready  = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunk_bytes <= CB_RESET;
            cfg_reg.chunk_count <= CCNT_RESET;
            cfg_reg.host_ready  <= 1'b0;
            refill_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            refill_reg <= cfg_we && (cfg_index == REG_CHUNK_COUNT);
        end
    end

    mcba_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .cfg   (cfg_reg),
        .full  (full),
        .busy  (busy),
        .push  (push),
        .job   (job_in)
    );

    mcba_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job_in),
        .pop   (pop),
        .dout  (job_out),
        .empty (empty),
        .full  (full)
    );

    mcba_back #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .refill     (refill_reg),
        .job        (job_out),
        .empty      (empty),
        .pop        (pop),
        .rsp        (rsp),
        .rsp_strobe (rsp_strobe)
    );

endmodule

// ===== rtl/core/mcba_front.sv =====
// ----------------------------------------------------------------------------
// mcba_front
// accepts requests, rejects bad ones and turns a byte size into a chunk count
// ----------------------------------------------------------------------------
module mcba_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mcba_pkg::req_t req,
    input  mcba_pkg::cfg_t cfg,
    input  logic          full,
    output logic          busy,
    output logic          push,
    output mcba_pkg::job_t job
);
    import mcba_pkg::*;

    localparam int DIV_ITERS = SIZE_W / DIV_STEPS;
    localparam int DCNT_W    = $clog2(DIV_ITERS);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_ITERS - 1);

    logic              active_reg, active_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0] dvd_reg, dvd_next;
    logic [CB_W-1:0]   rem_reg, rem_next;
    logic [SIZE_W-1:0] quo_step;
    logic [CB_W-1:0]   rem_step;
    logic [CB_W-1:0]   cb;
    logic              accept;

    assign cb     = eff_bytes(cfg.chunk_bytes);
    assign busy   = active_reg || full;
    assign accept = start && !busy;

    // radix-4 restoring divide, quotient shifts into the dividend register
    always_comb
    begin
        logic [CB_W:0]     trial;
        logic [CB_W-1:0]   r;
        logic [SIZE_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial = {r, d[SIZE_W-1]};
            d     = {d[SIZE_W-2:0], 1'b0};
            if (trial >= {1'b0, cb})
            begin
                trial = trial - {1'b0, cb};
                d[0]  = 1'b1;
            end
            r = trial[CB_W-1:0];
        end
        quo_step = d;
        rem_step = r;
    end

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        push        = 1'b0;
        job         = '0;
        job.chunk_index = req.chunk_index;
        if (active_reg)
        begin
            dvd_next = quo_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_LAST)
            begin
                active_next = 1'b0;
                push        = 1'b1;
                job.kind    = KIND_ALLOC;
                job.need    = quo_step + SIZE_W'(rem_step != '0);
            end
        end
        else if (accept)
        begin
            if (req.cmd == CMD_FREE)
            begin
                push     = 1'b1;
                job.kind = KIND_FREE;
            end
            else if (req.size_bytes == '0)
            begin
                push       = 1'b1;
                job.kind   = KIND_REJECT;
                job.status = STAT_ZERO;
            end
            else if (!cfg.host_ready)
            begin
                push       = 1'b1;
                job.kind   = KIND_REJECT;
                job.status = STAT_UNREG;
            end
            else
            begin
                active_next = 1'b1;
                cnt_next    = '0;
                dvd_next    = req.size_bytes;
                rem_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

endmodule

// ===== rtl/core/mcba_queue.sv =====
// ----------------------------------------------------------------------------
// mcba_queue
// short job queue between the request front and the pool back
// ----------------------------------------------------------------------------
module mcba_queue #(
    parameter int DEPTH = mcba_pkg::QDEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mcba_pkg::job_t din,
    input  logic           pop,
    output mcba_pkg::job_t dout,
    output logic           empty,
    output logic           full
);
    import mcba_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PTR_W + 1)'(DEPTH));
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue underflow");

endmodule

// ===== rtl/core/mcba_back.sv =====
// ----------------------------------------------------------------------------
// mcba_back
// free bitmap, counters and result generation, one granted chunk per beat
// ----------------------------------------------------------------------------
module mcba_back #(
    parameter int MAX_CHUNKS = mcba_pkg::MAX_CHUNKS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mcba_pkg::cfg_t cfg,
    input  logic           refill,
    input  mcba_pkg::job_t job,
    input  logic           empty,
    output logic           pop,
    output mcba_pkg::rsp_t rsp,
    output logic           rsp_strobe
);
    import mcba_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_GRANT = 1'b1;

    logic                   state_reg, state_next;
    logic [MAX_CHUNKS-1:0]  map_reg, map_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [CNT_W-1:0]       remain_reg, remain_next;
    logic [TALLY_W-1:0]     tally_reg, tally_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   strobe_reg, strobe_next;

    logic [CNT_W-1:0]       eff_cnt;
    logic [MAX_CHUNKS-1:0]  eff_mask;
    logic [IDX_W-1:0]       pick;
    logic [CB_W-1:0]        cb;
    logic [IDX_W+CB_W-1:0]  prod;
    logic [IDX_W-1:0]       free_idx;

    assign cb       = eff_bytes(cfg.chunk_bytes);
    assign prod     = pick * cb;
    assign free_idx = job.chunk_index[IDX_W-1:0];

    always_comb
    begin
        if (cfg.chunk_count == '0)
        begin
            eff_cnt = CNT_W'(1);
        end
        else if (cfg.chunk_count > CCNT_W'(MAX_CHUNKS))
        begin
            eff_cnt = CNT_W'(MAX_CHUNKS);
        end
        else
        begin
            eff_cnt = CNT_W'(cfg.chunk_count);
        end
        for (int i = 0; i < MAX_CHUNKS; i++)
        begin
            eff_mask[i] = (CNT_W'(i) < eff_cnt);
        end
    end

    // lowest free chunk
    always_comb
    begin
        pick = '0;
        for (int i = MAX_CHUNKS - 1; i >= 0; i--)
        begin
            if (map_reg[i])
            begin
                pick = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        map_next    = map_reg;
        total_next  = total_reg;
        remain_next = remain_reg;
        tally_next  = tally_reg;
        rsp_next    = rsp_reg;
        strobe_next = 1'b0;
        pop         = 1'b0;
        if (refill)
        begin
            map_next   = eff_mask;
            total_next = eff_cnt;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        pop         = 1'b1;
                        strobe_next = 1'b1;
                        rsp_next    = '0;
                        rsp_next.last = 1'b1;
                        case (job.kind)
                            KIND_FREE:
                            begin
                                if ({1'b0, job.chunk_index} >= CCNT_W'(eff_cnt))
                                begin
                                    rsp_next.status = STAT_UNKNOWN;
                                end
                                else if (map_reg[free_idx])
                                begin
                                    rsp_next.status = STAT_DOUBLE;
                                end
                                else
                                begin
                                    map_next[free_idx] = 1'b1;
                                    total_next         = total_reg + CNT_W'(1);
                                    rsp_next.status    = STAT_OK;
                                end
                            end
                            KIND_ALLOC:
                            begin
                                if (job.need > SIZE_W'(total_reg))
                                begin
                                    if (tally_reg != '1)
                                    begin
                                        tally_next = tally_reg + TALLY_W'(1);
                                    end
                                    rsp_next.status    = STAT_OUT;
                                    rsp_next.shortfall = job.need - SIZE_W'(total_reg);
                                end
                                else
                                begin
                                    strobe_next = 1'b0;
                                    total_next  = total_reg - CNT_W'(job.need);
                                    remain_next = CNT_W'(job.need);
                                    state_next  = ST_GRANT;
                                end
                            end
                            default:
                            begin
                                rsp_next.status = job.status;
                            end
                        endcase
                    end
                end
                ST_GRANT:
                begin
                    strobe_next            = 1'b1;
                    rsp_next               = '0;
                    rsp_next.status        = STAT_OK;
                    rsp_next.granted_chunk = CIDX_W'(pick);
                    rsp_next.byte_offset   = OFF_W'(prod);
                    rsp_next.last          = (remain_reg == CNT_W'(1));
                    map_next[pick]         = 1'b0;
                    remain_next            = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
        if (strobe_next)
        begin
            rsp_next.free_chunks     = FREE_W'(total_next);
            rsp_next.exhausted_count = tally_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            map_reg    <= '1;
            total_reg  <= CNT_W'(MAX_CHUNKS);
            remain_reg <= '0;
            tally_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            map_reg    <= map_next;
            total_reg  <= total_next;
            remain_reg <= remain_next;
            tally_reg  <= tally_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp        = rsp_reg;
    assign rsp_strobe = strobe_reg;

    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(map_reg) == (int'(total_reg) + int'(remain_reg)))
        else $error("free count out of step with bitmap");

    a_grant_has_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GRANT) |-> (map_reg != '0))
        else $error("grant with no free chunk");

    a_grant_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GRANT && !refill) |=> (rsp_strobe && rsp.status == STAT_OK))
        else $error("grant cycle without ok beat");

endmodule

// ===== sim/multi_chunk_buffer_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_chunk_buffer_allocator_tb
// drives allocate and free commands through a directed table and then random
// phases under several pool settings; every result beat is checked field by
// field against the table's beat or a behavioral pool kept alongside the block
// ----------------------------------------------------------------------------
module multi_chunk_buffer_allocator_tb;

    import mcba_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int DIR_ROWS     = 31;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 50;

    typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        req_t                 req;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_value;
        logic                 typed;
        rsp_t                 want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    req_t                 req = '0;
    rsp_t                 rsp;
    logic                 rsp_strobe;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int   mismatches = 0;
    rsp_t expected_beats[$];
    rsp_t model_beats[$];
    rsp_t due_beat;

    // chunk pool state and settings as the block should hold them
    logic [63:0]       pool_free_map;
    logic [FREE_W-1:0] pool_free_total;
    logic [31:0]       pool_tally;
    logic [CB_W-1:0]   set_chunk_bytes;
    logic [CCNT_W-1:0] set_chunk_count;
    logic              set_host_reg;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_REQ, '{CMD_ALLOC, 32'd0, 6'd0}, '0, '0, 1'b1,
          '{STAT_ZERO, 6'd0, 30'd0, 1'b1, 32'd0, 7'd64, 32'd0}},
        '{ROW_REQ, '{CMD_ALLOC, 32'hFFFF_FFFF, 6'd0}, '0, '0, 1'b1,
          '{STAT_UNREG, 6'd0, 30'd0, 1'b1, 32'd0, 7'd64, 32'd0}},
        '{ROW_REQ, '{CMD_FREE, 32'd0, 6'd0}, '0, '0, 1'b1,
          '{STAT_DOUBLE, 6'd0, 30'd0, 1'b1, 32'd0, 7'd64, 32'd0}},
        '{ROW_REQ, '{CMD_FREE, 32'hFFFF_FFFF, 6'd63}, '0, '0, 1'b1,
          '{STAT_DOUBLE, 6'd0, 30'd0, 1'b1, 32'd0, 7'd64, 32'd0}},
        '{ROW_CFG, '0, REG_HOST_REG, 25'd1, 1'b0, '0},
        '{ROW_REQ, '{CMD_ALLOC, 32'd1, 6'd0}, '0, '0, 1'b1,
          '{STAT_OK, 6'd0, 30'd0, 1'b1, 32'd0, 7'd63, 32'd0}},
        '{ROW_REQ, '{CMD_ALLOC, 32'hFFFF_FFFF, 6'd0}, '0, '0, 1'b1,
          '{STAT_OUT, 6'd0, 30'd0, 1'b1, 32'd1048513, 7'd63, 32'd1}},
        '{ROW_REQ, '{CMD_ALLOC, 32'd4097, 6'd0}, '0, '0, 1'b0, '0},
        '{ROW_REQ, '{CMD_FREE, 32'd0, 6'd1}, '0, '0, 1'b0, '0},
        '{ROW_REQ, '{CMD_FREE, 32'd0, 6'd1}, '0, '0, 1'b1,
          '{STAT_DOUBLE, 6'd0, 30'd0, 1'b1, 32'd0, 7'd62, 32'd1}},
        '{ROW_REQ, '{CMD_ALLOC, 32'd253952, 6'd0}, '0, '0, 1'b0, '0},
        '{ROW_REQ, '{CMD_ALLOC, 32'd1, 6'd0}, '0, '0, 1'b1,
          '{STAT_OUT, 6'd0, 30'd0, 1'b1, 32'd1, 7'd0, 32'd2}},
        '{ROW_CFG, '0, REG_CHUNK_COUNT, 25'd5, 1'b0, '0},
        '{ROW_REQ, '{CMD_FREE, 32'd0, 6'd5}, '0, '0, 1'b1,
          '{STAT_UNKNOWN, 6'd0, 30'd0, 1'b1, 32'd0, 7'd5, 32'd2}},
        '{ROW_REQ, '{CMD_FREE, 32'd0, 6'd63}, '0, '0, 1'b1,
          '{STAT_UNKNOWN, 6'd0, 30'd0, 1'b1, 32'd0, 7'd5, 32'd2}},
        '{ROW_REQ, '{CMD_ALLOC, 32'd20480, 6'd0}, '0, '0, 1'b0, '0},
        '{ROW_CFG, '0, REG_CHUNK_BYTES, 25'd0, 1'b0, '0},
        '{ROW_CFG, '0, REG_CHUNK_COUNT, 25'h1FF_FF80, 1'b0, '0},
        '{ROW_REQ, '{CMD_ALLOC, 32'd1, 6'd0}, '0, '0, 1'b1,
          '{STAT_OK, 6'd0, 30'd0, 1'b1, 32'd0, 7'd0, 32'd2}},
        '{ROW_REQ, '{CMD_FREE, 32'd0, 6'd1}, '0, '0, 1'b1,
          '{STAT_UNKNOWN, 6'd0, 30'd0, 1'b1, 32'd0, 7'd0, 32'd2}},
        '{ROW_REQ, '{CMD_FREE, 32'd0, 6'd0}, '0, '0, 1'b1,
          '{STAT_OK, 6'd0, 30'd0, 1'b1, 32'd0, 7'd1, 32'd2}},
        '{ROW_CFG, '0, REG_CHUNK_COUNT, 25'd127, 1'b0, '0},
        '{ROW_CFG, '0, REG_CHUNK_BYTES, 25'h1FF_FFFF, 1'b0, '0},
        '{ROW_REQ, '{CMD_ALLOC, 32'hFFFF_FFFF, 6'd0}, '0, '0, 1'b1,
          '{STAT_OUT, 6'd0, 30'd0, 1'b1, 32'd65, 7'd64, 32'd3}},
        '{ROW_REQ, '{CMD_ALLOC, 32'd2147483584, 6'd0}, '0, '0, 1'b0, '0},
        '{ROW_REQ, '{CMD_FREE, 32'd0, 6'd63}, '0, '0, 1'b0, '0},
        '{ROW_CFG, '0, REG_SPARE, 25'h1FF_FFFF, 1'b0, '0},
        '{ROW_REQ, '{CMD_ALLOC, 32'h01FF_FFFF, 6'd0}, '0, '0, 1'b0, '0},
        '{ROW_CFG, '0, REG_HOST_REG, 25'd0, 1'b0, '0},
        '{ROW_REQ, '{CMD_ALLOC, 32'd1, 6'd0}, '0, '0, 1'b1,
          '{STAT_UNREG, 6'd0, 30'd0, 1'b1, 32'd0, 7'd0, 32'd3}},
        '{ROW_REQ, '{CMD_FREE, 32'd0, 6'd63}, '0, '0, 1'b1,
          '{STAT_OK, 6'd0, 30'd0, 1'b1, 32'd0, 7'd1, 32'd3}}
    };

    multi_chunk_buffer_allocator uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .rsp        (rsp),
        .rsp_strobe (rsp_strobe),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [CCNT_W-1:0] pool_size();
        if (set_chunk_count == '0)
            return CCNT_W'(1);
        if (set_chunk_count > MAX_CHUNKS_DEF)
            return CCNT_W'(MAX_CHUNKS_DEF);
        return set_chunk_count;
    endfunction

    function automatic void pool_refill();
        logic [CCNT_W-1:0] n;
        n = pool_size();
        pool_free_map = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        pool_free_total = n;
    endfunction

    // one request against the pool, beats land in model_beats
    function automatic void pool_step(input req_t r);
        logic [63:0] unit;
        logic [63:0] need;
        int          granted[$];
        rsp_t        b;
        model_beats.delete();
        b = '0;
        b.last = 1'b1;
        unit = (set_chunk_bytes == '0) ? 64'd1 : 64'(set_chunk_bytes);
        if (r.cmd == CMD_FREE) begin
            if (r.chunk_index >= pool_size())
                b.status = STAT_UNKNOWN;
            else if (pool_free_map[r.chunk_index])
                b.status = STAT_DOUBLE;
            else
            begin
                pool_free_map[r.chunk_index] = 1'b1;
                pool_free_total = pool_free_total + 1'b1;
                b.status = STAT_OK;
            end
        end
        else if (r.size_bytes == '0)
            b.status = STAT_ZERO;
        else if (!set_host_reg)
            b.status = STAT_UNREG;
        else
        begin
            need = (64'(r.size_bytes) + unit - 64'd1) / unit;
            if (need > 64'(pool_free_total)) begin
                if (pool_tally != '1)
                    pool_tally = pool_tally + 1;
                b.status = STAT_OUT;
                b.shortfall = 32'(need - 64'(pool_free_total));
            end
            else
            begin
                for (int i = 0; i < 64; i++) begin
                    if (64'(granted.size()) < need && pool_free_map[i]) begin
                        pool_free_map[i] = 1'b0;
                        granted.insert(granted.size(), i);
                    end
                end
                pool_free_total = pool_free_total - FREE_W'(granted.size());
                foreach (granted[k]) begin
                    b.status = STAT_OK;
                    b.granted_chunk = CIDX_W'(granted[k]);
                    b.byte_offset = OFF_W'(64'(granted[k]) * unit);
                    b.last = (k == granted.size() - 1);
                    b.free_chunks = pool_free_total;
                    b.exhausted_count = pool_tally;
                    model_beats.insert(model_beats.size(), b);
                end
                return;
            end
        end
        b.free_chunks = pool_free_total;
        b.exhausted_count = pool_tally;
        model_beats.insert(model_beats.size(), b);
    endfunction

    // random chunk that is currently handed out, -1 if none
    function automatic int held_chunk();
        int n;
        int s;
        n = pool_size();
        s = $urandom_range(0, n - 1);
        for (int j = 0; j < n; j++) begin
            if (!pool_free_map[(s + j) % n])
                return (s + j) % n;
        end
        return -1;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_strobe) begin
            if (expected_beats.size() == 0) begin
                $display("%0t ns: beat with nothing expected, actual %p", $time, rsp);
                mismatches++;
            end
            else
            begin
                due_beat = expected_beats.pop_front();
                compare_field("status", due_beat.status, rsp.status);
                compare_field("granted_chunk", due_beat.granted_chunk, rsp.granted_chunk);
                compare_field("byte_offset", due_beat.byte_offset, rsp.byte_offset);
                compare_field("last", due_beat.last, rsp.last);
                compare_field("shortfall", due_beat.shortfall, rsp.shortfall);
                compare_field("free_chunks", due_beat.free_chunks, rsp.free_chunks);
                compare_field("exhausted_count", due_beat.exhausted_count,
                              rsp.exhausted_count);
            end
        end
    end

    // start stays high until the block takes the command
    task automatic issue_request(input req_t r, input logic typed, input rsp_t want);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pool_step(r);
        if (typed)
            expected_beats.insert(expected_beats.size(), want);
        else
            foreach (model_beats[k])
                expected_beats.insert(expected_beats.size(), model_beats[k]);
    endtask

    task automatic pause_sender();
        start <= 1'b0;
        repeat ($urandom_range(1, 15))
            @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_beats.size() != 0 || busy)
            @(posedge clk);
    endtask

    // caller lowers cfg_we after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        case (index)
            REG_CHUNK_BYTES: set_chunk_bytes = value;
            REG_CHUNK_COUNT:
            begin
                set_chunk_count = value[CCNT_W-1:0];
                pool_refill();
            end
            REG_HOST_REG: set_host_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic random_request(output req_t r);
        int          roll;
        int          k;
        int          idx;
        logic [63:0] unit;
        logic [63:0] size64;
        r.cmd = 1'($urandom_range(0, 1));
        r.size_bytes = $urandom;
        r.chunk_index = CIDX_W'($urandom);
        roll = $urandom_range(0, 99);
        unit = (set_chunk_bytes == '0) ? 64'd1 : 64'(set_chunk_bytes);
        if (roll < 45) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4);
            size64 = 64'(k - 1) * unit + 64'($urandom_range(1, 32'(unit)));
            r.cmd = CMD_ALLOC;
            r.size_bytes = (size64 > 64'hFFFF_FFFF) ? '1 : size64[31:0];
        end
        else if (roll < 80) begin
            idx = held_chunk();
            r.cmd = CMD_FREE;
            if (idx >= 0)
                r.chunk_index = CIDX_W'(idx);
        end
        else if (roll < 88)
            r.cmd = CMD_FREE;
        else if (roll < 95)
            r.cmd = CMD_ALLOC;
        else
        begin
            r.cmd = CMD_ALLOC;
            r.size_bytes = '0;
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        req_t              item;
        logic [CFG_W-1:0]  bytes_val;
        logic [CCNT_W-1:0] count_val;
        logic              quiet;

        set_chunk_bytes = CB_RESET;
        set_chunk_count = CCNT_RESET;
        set_host_reg = 1'b0;
        pool_tally = '0;
        pool_refill();

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_table[i].kind == ROW_CFG) begin
                if (i == 0 || dir_table[i-1].kind != ROW_CFG)
                    settle();
                write_reg(dir_table[i].reg_index, dir_table[i].reg_value);
                if (i == DIR_ROWS - 1 || dir_table[i+1].kind != ROW_CFG)
                    cfg_we <= 1'b0;
            end
            else
                issue_request(dir_table[i].req, dir_table[i].typed, dir_table[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            quiet = (phase == PHASES - 1);
            case ($urandom_range(0, 5))
                0: bytes_val = '0;
                1: bytes_val = 25'd1;
                2: bytes_val = '1;
                3: bytes_val = CFG_W'($urandom_range(2, 64));
                4: bytes_val = CFG_W'(CB_RESET);
                default: bytes_val = CFG_W'($urandom);
            endcase
            case ($urandom_range(0, 6))
                0: count_val = 7'd0;
                1: count_val = 7'd1;
                2: count_val = 7'd2;
                3: count_val = 7'd64;
                4: count_val = CCNT_W'($urandom_range(65, 127));
                default: count_val = CCNT_W'($urandom_range(3, 63));
            endcase
            settle();
            write_reg(REG_CHUNK_BYTES, bytes_val);
            write_reg(REG_CHUNK_COUNT, {18'($urandom), count_val});
            write_reg(REG_HOST_REG, {24'($urandom), quiet || ($urandom_range(0, 4) != 0)});
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, CFG_W'($urandom));
            cfg_we <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (!quiet && $urandom_range(0, 3) == 0)
                    pause_sender();
                random_request(item);
                issue_request(item, 1'b0, '0);
            end
        end

        settle();
        repeat (40)
            @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
